FILE: design/sm83_pkg.sv
// shared types and constants for the sm83 core subset
package sm83_pkg;
    localparam int unsigned ADDR_W = 16;
    localparam int unsigned DATA_W = 8;
    localparam int unsigned CYC_W  = 5;
    localparam int unsigned CFG_IDX_W = 1;

    localparam logic [CFG_IDX_W-1:0] CFG_START_ADDRESS = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_STACK_START   = 1'd1;

    localparam logic [15:0] HIGH_PAGE = 16'hFF00;
    localparam logic [15:0] START_RESET = 16'h0000;
    localparam logic [15:0] STACK_RESET = 16'hFFFE;

    localparam logic [7:0] OP_HALT = 8'h76;
    localparam logic [7:0] OP_NOP  = 8'h00;
    localparam logic [7:0] OP_LDSP = 8'h08;
    localparam logic [7:0] OP_JR   = 8'h18;
    localparam logic [7:0] OP_JP   = 8'hC3;
    localparam logic [7:0] OP_CALL = 8'hCD;
    localparam logic [7:0] OP_RET  = 8'hC9;
    localparam logic [7:0] OP_ADDSP = 8'hE8;
    localparam logic [7:0] OP_JPHL = 8'hE9;
    localparam logic [7:0] OP_LDHLSP = 8'hF8;
    localparam logic [7:0] OP_LDSPHL = 8'hF9;

    typedef struct packed {
        logic [ADDR_W-1:0] bus_address;
        logic              bus_write;
        logic [DATA_W-1:0] bus_write_data;
        logic              instr_done;
        logic [CYC_W-1:0]  instr_cycles;
        logic              unhandled_opcode;
    } req_t;

    typedef struct packed {
        logic [7:0]  a;
        logic [3:0]  f;
        logic [7:0]  b, c, d, e, h, l;
        logic [15:0] sp;
        logic [15:0] pc;
        logic [7:0]  op;
        logic [2:0]  step;
        logic [15:0] tmp;
    } cpu_state_t;
endpackage

FILE: design/sm83_if.sv
// valid/ready channel interfaces
interface sm83_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] read_data;
    modport source (output valid, output read_data, input ready);
    modport sink (input valid, input read_data, output ready);
endinterface

interface sm83_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] bus_address;
    logic        bus_write;
    logic [7:0]  bus_write_data;
    logic        instr_done;
    logic [4:0]  instr_cycles;
    logic        unhandled_opcode;
    modport source (output valid, output bus_address, output bus_write, output bus_write_data,
                    output instr_done, output instr_cycles, output unhandled_opcode,
                    input ready);
    modport sink (input valid, input bus_address, input bus_write, input bus_write_data,
                  input instr_done, input instr_cycles, input unhandled_opcode,
                  output ready);
endinterface

interface sm83_cfg_if;
    logic        valid;
    logic        ready;
    logic        index;
    logic [15:0] data;
    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

FILE: design/sm83_exec.sv
// combinational next-state and bus request for one bus transfer
module sm83_exec (
    input  sm83_pkg::cpu_state_t cur,
    input  logic [7:0]           din,
    input  logic [15:0]          start_address,
    input  logic [15:0]          stack_start,
    output sm83_pkg::cpu_state_t nxt,
    output sm83_pkg::req_t       req
);
    import sm83_pkg::*;

    logic [7:0]  op;
    logic [2:0]  s, x, z;
    logic [1:0]  p;
    logic        more, unh, wr, ldb;
    logic [15:0] addr, hlv, pv, sx, pushv;
    logic [7:0]  wdat, src, idr;
    logic [4:0]  cyc;
    logic [8:0]  r9;
    logic [16:0] r17;
    logic        hc;

    function automatic logic [7:0] get_r8(input cpu_state_t t, input logic [2:0] i);
        case (i)
            3'd0: get_r8 = t.b;
            3'd1: get_r8 = t.c;
            3'd2: get_r8 = t.d;
            3'd3: get_r8 = t.e;
            3'd4: get_r8 = t.h;
            3'd5: get_r8 = t.l;
            3'd7: get_r8 = t.a;
            default: get_r8 = 8'h00;
        endcase
    endfunction

    function automatic cpu_state_t set_r8(input cpu_state_t t, input logic [2:0] i,
                                          input logic [7:0] v);
        cpu_state_t o;
        o = t;
        case (i)
            3'd0: o.b = v;
            3'd1: o.c = v;
            3'd2: o.d = v;
            3'd3: o.e = v;
            3'd4: o.h = v;
            3'd5: o.l = v;
            3'd7: o.a = v;
            default: o = t;
        endcase
        return o;
    endfunction

    function automatic logic [15:0] get_pair(input cpu_state_t t, input logic [1:0] i);
        case (i)
            2'd0: get_pair = {t.b, t.c};
            2'd1: get_pair = {t.d, t.e};
            2'd2: get_pair = {t.h, t.l};
            default: get_pair = t.sp;
        endcase
    endfunction

    function automatic cpu_state_t set_pair(input cpu_state_t t, input logic [1:0] i,
                                            input logic [15:0] v);
        cpu_state_t o;
        o = t;
        case (i)
            2'd0: {o.b, o.c} = v;
            2'd1: {o.d, o.e} = v;
            2'd2: {o.h, o.l} = v;
            default: o.sp = v;
        endcase
        return o;
    endfunction

    function automatic logic cond(input logic [3:0] f, input logic [1:0] c);
        case (c)
            2'd0: cond = !f[3];
            2'd1: cond = f[3];
            2'd2: cond = !f[0];
            default: cond = f[0];
        endcase
    endfunction

    function automatic cpu_state_t alu(input cpu_state_t t, input logic [2:0] o,
                                       input logic [7:0] v);
        cpu_state_t r;
        logic       ci;
        logic [8:0] sum;
        logic [4:0] hs;
        logic [7:0] res;
        r = t;
        ci = 1'b0;
        sum = '0;
        hs = '0;
        res = '0;
        case (o)
            3'd0, 3'd1:
            begin
                ci = (o == 3'd1) ? t.f[0] : 1'b0;
                sum = {1'b0, t.a} + {1'b0, v} + {8'd0, ci};
                hs = {1'b0, t.a[3:0]} + {1'b0, v[3:0]} + {4'd0, ci};
                r.a = sum[7:0];
                r.f = {sum[7:0] == 8'd0, 1'b0, hs[4], sum[8]};
            end
            3'd2, 3'd3, 3'd7:
            begin
                ci = (o == 3'd3) ? t.f[0] : 1'b0;
                sum = {1'b0, t.a} - {1'b0, v} - {8'd0, ci};
                hs = {1'b0, t.a[3:0]} - {1'b0, v[3:0]} - {4'd0, ci};
                r.f = {sum[7:0] == 8'd0, 1'b1, hs[4], sum[8]};
                if (o != 3'd7)
                begin
                    r.a = sum[7:0];
                end
            end
            3'd4:
            begin
                res = t.a & v;
                r.a = res;
                r.f = {res == 8'd0, 1'b0, 1'b1, 1'b0};
            end
            3'd5:
            begin
                res = t.a ^ v;
                r.a = res;
                r.f = {res == 8'd0, 3'b000};
            end
            default:
            begin
                res = t.a | v;
                r.a = res;
                r.f = {res == 8'd0, 3'b000};
            end
        endcase
        return r;
    endfunction

    always_comb
    begin
        op = (cur.step == 3'd1) ? din : cur.op;
        s = cur.step - 3'd1;
        x = op[5:3];
        z = op[2:0];
        p = op[5:4];
        ldb = op[4];
        hlv = {cur.h, cur.l};
        nxt = cur;
        nxt.op = op;
        more = 1'b1;
        unh = 1'b0;
        wr = 1'b0;
        addr = cur.pc;
        wdat = 8'h00;
        cyc = '0;
        sx = {{8{din[7]}}, din};
        pv = get_pair(cur, p);
        pushv = (p == 2'd3) ? {cur.a, cur.f, 4'h0} : pv;
        src = get_r8(cur, z);
        idr = 8'h00;
        r9 = '0;
        r17 = '0;
        hc = 1'b0;
        if (cur.step == 3'd0)
        begin
            nxt.pc = start_address;
            nxt.sp = stack_start;
            more = 1'b0;
        end
        else if (op[7:6] == 2'b01)
        begin
            if (op == OP_HALT)
            begin
                more = 1'b0; cyc = 5'd4;
            end
            else if (z == 3'd6)
            begin
                if (s == 3'd0) addr = hlv;
                else
                begin
                    nxt = set_r8(nxt, x, din); more = 1'b0; cyc = 5'd8;
                end
            end
            else if (x == 3'd6)
            begin
                if (s == 3'd0)
                begin
                    addr = hlv; wr = 1'b1; wdat = src;
                end
                else
                begin
                    more = 1'b0; cyc = 5'd8;
                end
            end
            else
            begin
                nxt = set_r8(nxt, x, src); more = 1'b0; cyc = 5'd4;
            end
        end
        else if (op[7:6] == 2'b10)
        begin
            if (z != 3'd6)
            begin
                nxt = alu(nxt, x, src); more = 1'b0; cyc = 5'd4;
            end
            else if (s == 3'd0) addr = hlv;
            else
            begin
                nxt = alu(nxt, x, din); more = 1'b0; cyc = 5'd8;
            end
        end
        else if ((op & 8'hC7) == 8'h06)
        begin
            if (s == 3'd0)
            begin
                addr = cur.pc; nxt.pc = cur.pc + 16'd1;
            end
            else if (x != 3'd6)
            begin
                nxt = set_r8(nxt, x, din); more = 1'b0; cyc = 5'd8;
            end
            else if (s == 3'd1)
            begin
                addr = hlv; wr = 1'b1; wdat = din;
            end
            else
            begin
                more = 1'b0; cyc = 5'd12;
            end
        end
        else if ((op & 8'hC6) == 8'h04)
        begin
            idr = (x == 3'd6) ? din : get_r8(cur, x);
            if (z[0])
            begin
                hc = idr[3:0] == 4'd0; idr = idr - 8'd1;
            end
            else
            begin
                hc = idr[3:0] == 4'hF; idr = idr + 8'd1;
            end
            if (x != 3'd6)
            begin
                nxt = set_r8(nxt, x, idr);
                nxt.f = {idr == 8'd0, z[0], hc, cur.f[0]};
                more = 1'b0; cyc = 5'd4;
            end
            else if (s == 3'd0) addr = hlv;
            else if (s == 3'd1)
            begin
                nxt.f = {idr == 8'd0, z[0], hc, cur.f[0]};
                addr = hlv; wr = 1'b1; wdat = idr;
            end
            else
            begin
                more = 1'b0; cyc = 5'd12;
            end
        end
        else if ((op & 8'hCF) == 8'h01 || (op & 8'hE7) == 8'hC2 || op == OP_JP
                 || op == OP_CALL || (op & 8'hE7) == 8'hC4 || op == OP_LDSP
                 || (op & 8'hEF) == 8'hEA)
        begin
            // two-byte immediate, then per-opcode tail
            if (s == 3'd0)
            begin
                addr = cur.pc; nxt.pc = cur.pc + 16'd1;
            end
            else if (s == 3'd1)
            begin
                nxt.tmp = {8'd0, din}; addr = cur.pc; nxt.pc = cur.pc + 16'd1;
            end
            else
            begin
                if (s == 3'd2) nxt.tmp = {din, cur.tmp[7:0]};
                if ((op & 8'hCF) == 8'h01)
                begin
                    nxt = set_pair(nxt, p, nxt.tmp); more = 1'b0; cyc = 5'd12;
                end
                else if ((op & 8'hE7) == 8'hC2 || op == OP_JP)
                begin
                    more = 1'b0;
                    if (op == OP_JP || cond(cur.f, x[1:0]))
                    begin
                        nxt.pc = nxt.tmp; cyc = 5'd16;
                    end
                    else cyc = 5'd12;
                end
                else if (op == OP_LDSP)
                begin
                    if (s == 3'd2)
                    begin
                        addr = nxt.tmp; wr = 1'b1; wdat = cur.sp[7:0];
                    end
                    else if (s == 3'd3)
                    begin
                        addr = cur.tmp + 16'd1; wr = 1'b1; wdat = cur.sp[15:8];
                    end
                    else
                    begin
                        more = 1'b0; cyc = 5'd20;
                    end
                end
                else if ((op & 8'hEF) == 8'hEA)
                begin
                    if (s == 3'd2)
                    begin
                        addr = nxt.tmp; wr = !ldb; wdat = ldb ? 8'h00 : cur.a;
                    end
                    else
                    begin
                        if (ldb) nxt.a = din;
                        more = 1'b0; cyc = 5'd16;
                    end
                end
                else
                begin
                    if (s == 3'd2)
                    begin
                        if (op != OP_CALL && !cond(cur.f, x[1:0]))
                        begin
                            more = 1'b0; cyc = 5'd12;
                        end
                        else
                        begin
                            nxt.sp = cur.sp - 16'd1; addr = nxt.sp;
                            wr = 1'b1; wdat = cur.pc[15:8];
                        end
                    end
                    else if (s == 3'd3)
                    begin
                        nxt.sp = cur.sp - 16'd1; addr = nxt.sp;
                        wr = 1'b1; wdat = cur.pc[7:0];
                    end
                    else
                    begin
                        nxt.pc = cur.tmp; more = 1'b0; cyc = 5'd24;
                    end
                end
            end
        end
        else if ((op & 8'hE7) == 8'h20 || op == OP_JR)
        begin
            if (s == 3'd0)
            begin
                addr = cur.pc; nxt.pc = cur.pc + 16'd1;
            end
            else if (op == OP_JR || cond(cur.f, x[1:0]))
            begin
                nxt.pc = cur.pc + sx; more = 1'b0; cyc = 5'd12;
            end
            else
            begin
                more = 1'b0; cyc = 5'd8;
            end
        end
        else if ((op & 8'hCF) == 8'hC5)
        begin
            if (s >= 3'd2)
            begin
                more = 1'b0; cyc = 5'd16;
            end
            else
            begin
                nxt.sp = cur.sp - 16'd1; addr = nxt.sp; wr = 1'b1;
                wdat = (s == 3'd0) ? pushv[15:8] : pushv[7:0];
            end
        end
        else if ((op & 8'hCF) == 8'hC1 || (op & 8'hE7) == 8'hC0 || op == OP_RET)
        begin
            if ((op & 8'hE7) == 8'hC0 && s == 3'd0 && !cond(cur.f, x[1:0]))
            begin
                more = 1'b0; cyc = 5'd8;
            end
            else if (s > 3'd1)
            begin
                nxt.tmp = {din, cur.tmp[7:0]};
                more = 1'b0;
                if ((op & 8'hCF) == 8'hC1)
                begin
                    cyc = 5'd12;
                    if (p == 2'd3)
                    begin
                        nxt.a = din; nxt.f = cur.tmp[7:4];
                    end
                    else nxt = set_pair(nxt, p, nxt.tmp);
                end
                else
                begin
                    nxt.pc = nxt.tmp;
                    cyc = (op == OP_RET) ? 5'd16 : 5'd20;
                end
            end
            else
            begin
                if (s == 3'd1) nxt.tmp = {8'd0, din};
                addr = cur.sp; nxt.sp = cur.sp + 16'd1;
            end
        end
        else if ((op & 8'hC7) == 8'h02)
        begin
            if (s == 3'd0)
            begin
                addr = (p[1] == 1'b0) ? pv : hlv;
                wr = !op[3]; wdat = op[3] ? 8'h00 : cur.a;
                if (p == 2'd2) {nxt.h, nxt.l} = hlv + 16'd1;
                if (p == 2'd3) {nxt.h, nxt.l} = hlv - 16'd1;
            end
            else
            begin
                if (op[3]) nxt.a = din;
                more = 1'b0; cyc = 5'd8;
            end
        end
        else if ((op & 8'hEF) == 8'hE0)
        begin
            if (s == 3'd0)
            begin
                addr = cur.pc; nxt.pc = cur.pc + 16'd1;
            end
            else if (s == 3'd1)
            begin
                addr = HIGH_PAGE | {8'd0, din}; wr = !ldb; wdat = ldb ? 8'h00 : cur.a;
            end
            else
            begin
                if (ldb) nxt.a = din;
                more = 1'b0; cyc = 5'd12;
            end
        end
        else if ((op & 8'hEF) == 8'hE2)
        begin
            if (s == 3'd0)
            begin
                addr = HIGH_PAGE | {8'd0, cur.c}; wr = !ldb; wdat = ldb ? 8'h00 : cur.a;
            end
            else
            begin
                if (ldb) nxt.a = din;
                more = 1'b0; cyc = 5'd8;
            end
        end
        else if ((op & 8'hC7) == 8'h03)
        begin
            nxt = set_pair(nxt, p, op[3] ? pv - 16'd1 : pv + 16'd1);
            more = 1'b0; cyc = 5'd8;
        end
        else if ((op & 8'hCF) == 8'h09)
        begin
            r17 = {1'b0, hlv} + {1'b0, pv};
            hc = ({1'b0, hlv[11:0]} + {1'b0, pv[11:0]}) > 13'h0FFF;
            {nxt.h, nxt.l} = r17[15:0];
            nxt.f = {cur.f[3], 1'b0, hc, r17[16]};
            more = 1'b0; cyc = 5'd8;
        end
        else if ((op & 8'hC7) == 8'hC6)
        begin
            if (s == 3'd0)
            begin
                addr = cur.pc; nxt.pc = cur.pc + 16'd1;
            end
            else
            begin
                nxt = alu(nxt, x, din); more = 1'b0; cyc = 5'd8;
            end
        end
        else if (op == OP_ADDSP || op == OP_LDHLSP)
        begin
            if (s == 3'd0)
            begin
                addr = cur.pc; nxt.pc = cur.pc + 16'd1;
            end
            else
            begin
                r9 = {1'b0, cur.sp[7:0]} + {1'b0, din};
                hc = ({1'b0, cur.sp[3:0]} + {1'b0, din[3:0]}) > 5'd15;
                if (op == OP_ADDSP)
                begin
                    nxt.sp = cur.sp + sx; cyc = 5'd16;
                end
                else
                begin
                    {nxt.h, nxt.l} = cur.sp + sx; cyc = 5'd12;
                end
                nxt.f = {2'b00, hc, r9[8]};
                more = 1'b0;
            end
        end
        else if (op == OP_NOP)
        begin
            more = 1'b0; cyc = 5'd4;
        end
        else if (op == OP_JPHL)
        begin
            nxt.pc = hlv; more = 1'b0; cyc = 5'd4;
        end
        else if (op == OP_LDSPHL)
        begin
            nxt.sp = hlv; more = 1'b0; cyc = 5'd8;
        end
        else
        begin
            more = 1'b0; unh = 1'b1;
        end

        if (more)
        begin
            nxt.step = cur.step + 3'd1;
        end
        else
        begin
            addr = nxt.pc;
            wr = 1'b0;
            wdat = 8'h00;
            nxt.pc = nxt.pc + 16'd1;
            nxt.step = 3'd1;
        end
        req.bus_address = addr;
        req.bus_write = wr;
        req.bus_write_data = wr ? wdat : 8'h00;
        req.instr_done = !more && (cur.step != 3'd0);
        req.instr_cycles = req.instr_done ? cyc : 5'd0;
        req.unhandled_opcode = req.instr_done && unh;
    end
endmodule

FILE: design/sm83_cpu_core_subset.sv
// sm83 cpu core subset top level
// Each accepted read_data transfer advances the core by one bus access and produces exactly
// one bus request on the output channel, one per cycle when the sink keeps ready high. The
// request is held in an output register and a new transfer is taken whenever that register
// is empty or being drained in the same cycle. The first transfer after reset ignores its
// data, loads PC and SP from start_address and stack_start, and issues the first opcode
// fetch. Configuration written after that first transfer is not used: reset restores the defaults.
module sm83_cpu_core_subset (
    input  logic clk,
    input  logic rst_n,
    sm83_in_if.sink    in_ch,
    sm83_out_if.source out_ch,
    sm83_cfg_if.sink   cfg
);
    import sm83_pkg::*;

    cpu_state_t state_reg, state_next;
    req_t       req_reg, req_next;
    logic       valid_reg;
    logic [15:0] start_reg, stack_reg;
    logic       take;

    sm83_exec u_exec (
        .cur(state_reg), .din(in_ch.read_data),
        .start_address(start_reg), .stack_start(stack_reg),
        .nxt(state_next), .req(req_next)
    );

    assign cfg.ready = 1'b1;
    assign in_ch.ready = !valid_reg || out_ch.ready;
    assign take = in_ch.valid && in_ch.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_reg <= START_RESET;
            stack_reg <= STACK_RESET;
            state_reg <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg.valid)
            begin
                case (cfg.index)
                    CFG_START_ADDRESS: start_reg <= cfg.data;
                    default: stack_reg <= cfg.data;
                endcase
            end
            if (take)
            begin
                state_reg <= state_next;
                valid_reg <= 1'b1;
            end
            else if (out_ch.ready)
            begin
                valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            req_reg <= req_next;
        end
    end

    assign out_ch.valid = valid_reg;
    assign out_ch.bus_address = req_reg.bus_address;
    assign out_ch.bus_write = req_reg.bus_write;
    assign out_ch.bus_write_data = req_reg.bus_write_data;
    assign out_ch.instr_done = req_reg.instr_done;
    assign out_ch.instr_cycles = req_reg.instr_cycles;
    assign out_ch.unhandled_opcode = req_reg.unhandled_opcode;
endmodule

FILE: design/sm83_checker.sv
// port-level checker for the sm83 core subset, bound to the top level
module sm83_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        bus_write,
    input logic [7:0]  bus_write_data,
    input logic        instr_done,
    input logic [4:0]  instr_cycles,
    input logic        unhandled_opcode
);
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready) else $error("input not ready with empty output");
    a_out_after_in: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> out_valid) else $error("transfer gave no request");
    a_unh_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && unhandled_opcode) |-> (instr_done && instr_cycles == 5'd0))
        else $error("unhandled opcode with cycles");
    a_done_read: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && instr_done) |-> !bus_write) else $error("fetch marked as write");
    a_read_data: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !bus_write) |-> bus_write_data == 8'h00)
        else $error("read carries write data");
endmodule

bind sm83_cpu_core_subset sm83_checker u_sm83_checker (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .out_valid(out_ch.valid),
    .bus_write(out_ch.bus_write), .bus_write_data(out_ch.bus_write_data),
    .instr_done(out_ch.instr_done), .instr_cycles(out_ch.instr_cycles),
    .unhandled_opcode(out_ch.unhandled_opcode)
);

FILE: tb/sv/sm83_bus_checker.sv
`timescale 1ns / 1ps
// checker for the sm83 core subset: predicts every bus request and compares it
module sm83_bus_checker (
    input  logic clk,
    input  logic rst_n,
    sm83_in_if  in_ch,
    sm83_out_if out_ch,
    sm83_cfg_if cfg,
    output int   errors,
    output int   backlog
);
    import sm83_pkg::*;

    localparam logic [2:0] ALU_ADD = 3'd0;
    localparam logic [2:0] ALU_ADC = 3'd1;
    localparam logic [2:0] ALU_SUB = 3'd2;
    localparam logic [2:0] ALU_SBC = 3'd3;
    localparam logic [2:0] ALU_AND = 3'd4;
    localparam logic [2:0] ALU_XOR = 3'd5;
    localparam logic [2:0] ALU_OR  = 3'd6;
    localparam logic [2:0] ALU_CP  = 3'd7;

    localparam logic [2:0] REG_C   = 3'd1;
    localparam logic [2:0] REG_MEM = 3'd6;
    localparam logic [2:0] REG_A   = 3'd7;
    localparam logic [1:0] PAIR_HL = 2'd2;
    localparam logic [1:0] PAIR_SP = 2'd3;

    logic [15:0] start_reg, stack_reg;
    logic [7:0]  acc;
    logic [3:0]  flags;
    logic [7:0]  gpr [6];
    logic [15:0] sp, pc, tmp;
    logic [7:0]  op_latch;
    logic [2:0]  mstep;

    logic [15:0] rq_addr;
    logic        rq_wr;
    logic [7:0]  rq_data;
    logic        rq_more;
    logic [4:0]  rq_cyc;
    logic        rq_unh;

    req_t expected_reqs[$];

    function automatic void bus_read(input logic [15:0] a);
        rq_addr = a; rq_wr = 1'b0; rq_data = 8'h00; rq_more = 1'b1;
    endfunction

    function automatic void bus_store(input logic [15:0] a, input logic [7:0] v);
        rq_addr = a; rq_wr = 1'b1; rq_data = v; rq_more = 1'b1;
    endfunction

    function automatic void finish_instr(input logic [4:0] c);
        rq_more = 1'b0; rq_cyc = c;
    endfunction

    function automatic void fetch_pc();
        bus_read(pc);
        pc = pc + 16'd1;
    endfunction

    function automatic logic [15:0] hl_word();
        return {gpr[4], gpr[5]};
    endfunction

    function automatic logic [15:0] reg_pair(input logic [1:0] p);
        if (p == PAIR_SP)
            return sp;
        return {gpr[2*p], gpr[2*p+1]};
    endfunction

    function automatic void set_reg_pair(input logic [1:0] p, input logic [15:0] v);
        if (p == PAIR_SP)
            sp = v;
        else
        begin
            gpr[2*p]   = v[15:8];
            gpr[2*p+1] = v[7:0];
        end
    endfunction

    function automatic logic [7:0] read_r8(input logic [2:0] i);
        if (i < REG_MEM)
            return gpr[i];
        if (i == REG_A)
            return acc;
        return 8'h00;
    endfunction

    function automatic void write_r8(input logic [2:0] i, input logic [7:0] v);
        if (i < REG_MEM)
            gpr[i] = v;
        else if (i == REG_A)
            acc = v;
    endfunction

    function automatic void set_flags(input bit z, input bit n, input bit h, input bit c);
        flags = {z, n, h, c};
    endfunction

    function automatic bit cond_met(input logic [1:0] c);
        case (c)
            2'd0: return !flags[3];
            2'd1: return flags[3];
            2'd2: return !flags[0];
            default: return flags[0];
        endcase
    endfunction

    function automatic logic [15:0] sext16(input logic [7:0] d);
        return {{8{d[7]}}, d};
    endfunction

    function automatic void alu_exec(input logic [2:0] op, input logic [7:0] v);
        int a, vi, ci, r;
        a = acc; vi = v; ci = flags[0];
        case (op)
            ALU_ADD, ALU_ADC:
            begin
                if (op == ALU_ADD)
                    ci = 0;
                r = a + vi + ci;
                acc = r[7:0];
                set_flags(acc == 0, 1'b0, (a % 16) + (vi % 16) + ci > 15, r > 255);
            end
            ALU_SUB, ALU_SBC, ALU_CP:
            begin
                if (op != ALU_SBC)
                    ci = 0;
                r = (a - vi - ci) & 255;
                set_flags(r == 0, 1'b1, (a % 16) < (vi % 16) + ci, a < vi + ci);
                if (op != ALU_CP)
                    acc = r[7:0];
            end
            ALU_AND:
            begin
                acc = acc & v;
                set_flags(acc == 0, 1'b0, 1'b1, 1'b0);
            end
            ALU_XOR:
            begin
                acc = acc ^ v;
                set_flags(acc == 0, 1'b0, 1'b0, 1'b0);
            end
            default:
            begin
                acc = acc | v;
                set_flags(acc == 0, 1'b0, 1'b0, 1'b0);
            end
        endcase
    endfunction

    function automatic logic [7:0] inc_dec(input logic [7:0] v, input bit dec);
        bit h;
        h = dec ? (v[3:0] == 4'h0) : (v[3:0] == 4'hF);
        v = dec ? v - 8'd1 : v + 8'd1;
        set_flags(v == 0, dec, h, flags[0]);
        return v;
    endfunction

    // two-byte immediate, word ready in tmp at stage 2
    function automatic bit imm16(input logic [2:0] s, input logic [7:0] d);
        if (s == 0)
        begin
            fetch_pc();
            return 1'b0;
        end
        if (s == 1)
        begin
            tmp = {8'h00, d};
            fetch_pc();
            return 1'b0;
        end
        tmp = {d, tmp[7:0]};
        return 1'b1;
    endfunction

    function automatic bit pop_word(input logic [2:0] s, input logic [7:0] d);
        if (s > 1)
        begin
            tmp = {d, tmp[7:0]};
            return 1'b1;
        end
        if (s == 1)
            tmp = {8'h00, d};
        bus_read(sp);
        sp = sp + 16'd1;
        return 1'b0;
    endfunction

    function automatic void call_step(input logic [2:0] s, input logic [7:0] d, input bit take);
        if (s <= 2 && !imm16(s, d))
            return;
        if (s == 2)
        begin
            if (!take)
            begin
                finish_instr(5'd12);
                return;
            end
            sp = sp - 16'd1;
            bus_store(sp, pc[15:8]);
        end
        else if (s == 3)
        begin
            sp = sp - 16'd1;
            bus_store(sp, pc[7:0]);
        end
        else
        begin
            pc = tmp;
            finish_instr(5'd24);
        end
    endfunction

    function automatic void sp_offset(input logic [7:0] d, input bit to_hl, input logic [4:0] cyc);
        logic [15:0] r;
        bit c, h;
        r = sp + sext16(d);
        c = (int'(sp[7:0]) + int'(d)) > 255;
        h = (int'(sp[3:0]) + int'(d[3:0])) > 15;
        if (to_hl)
            set_reg_pair(PAIR_HL, r);
        else
            sp = r;
        set_flags(1'b0, 1'b0, h, c);
        finish_instr(cyc);
    endfunction

    function automatic void exec_op(input logic [7:0] op, input logic [2:0] s, input logic [7:0] d);
        logic [2:0]  x, z;
        logic [1:0]  p;
        logic [15:0] v, a;
        int          wa, wb;
        bit          hi_ld, load, dec;
        x = op[5:3]; z = op[2:0]; p = op[5:4]; hi_ld = op[4];

        if (op >= 8'h40 && op <= 8'h7F)
        begin
            if (op == OP_HALT)
                finish_instr(5'd4);
            else if (z == REG_MEM)
            begin
                if (s == 0) bus_read(hl_word());
                else
                begin
                    write_r8(x, d);
                    finish_instr(5'd8);
                end
            end
            else if (x == REG_MEM)
            begin
                if (s == 0) bus_store(hl_word(), read_r8(z));
                else finish_instr(5'd8);
            end
            else
            begin
                write_r8(x, read_r8(z));
                finish_instr(5'd4);
            end
            return;
        end
        if (op >= 8'h80 && op <= 8'hBF)
        begin
            if (z != REG_MEM)
            begin
                alu_exec(x, read_r8(z));
                finish_instr(5'd4);
            end
            else if (s == 0)
                bus_read(hl_word());
            else
            begin
                alu_exec(x, d);
                finish_instr(5'd8);
            end
            return;
        end
        if ((op & 8'hC7) == 8'h06)
        begin
            if (s == 0) fetch_pc();
            else if (x != REG_MEM)
            begin
                write_r8(x, d);
                finish_instr(5'd8);
            end
            else if (s == 1) bus_store(hl_word(), d);
            else finish_instr(5'd12);
            return;
        end
        if ((op & 8'hC7) == 8'h04 || (op & 8'hC7) == 8'h05)
        begin
            dec = (z == 3'd5);
            if (x != REG_MEM)
            begin
                write_r8(x, inc_dec(read_r8(x), dec));
                finish_instr(5'd4);
            end
            else if (s == 0) bus_read(hl_word());
            else if (s == 1) bus_store(hl_word(), inc_dec(d, dec));
            else finish_instr(5'd12);
            return;
        end
        if ((op & 8'hCF) == 8'h01)
        begin
            if (imm16(s, d))
            begin
                set_reg_pair(p, tmp);
                finish_instr(5'd12);
            end
            return;
        end
        if ((op & 8'hE7) == 8'h20)
        begin
            if (s == 0) fetch_pc();
            else if (cond_met(x[1:0]))
            begin
                pc = pc + sext16(d);
                finish_instr(5'd12);
            end
            else finish_instr(5'd8);
            return;
        end
        if ((op & 8'hE7) == 8'hC2)
        begin
            if (imm16(s, d))
            begin
                if (cond_met(x[1:0]))
                begin
                    pc = tmp;
                    finish_instr(5'd16);
                end
                else finish_instr(5'd12);
            end
            return;
        end
        if ((op & 8'hCF) == 8'hC5)
        begin
            v = (p == PAIR_SP) ? {acc, flags, 4'h0} : reg_pair(p);
            if (s >= 2)
            begin
                finish_instr(5'd16);
                return;
            end
            sp = sp - 16'd1;
            bus_store(sp, (s == 0) ? v[15:8] : v[7:0]);
            return;
        end
        if ((op & 8'hCF) == 8'hC1)
        begin
            if (pop_word(s, d))
            begin
                if (p == PAIR_SP)
                begin
                    acc = tmp[15:8];
                    flags = tmp[7:4];
                end
                else set_reg_pair(p, tmp);
                finish_instr(5'd12);
            end
            return;
        end
        if ((op & 8'hE7) == 8'hC4)
        begin
            call_step(s, d, cond_met(x[1:0]));
            return;
        end
        if ((op & 8'hE7) == 8'hC0)
        begin
            if (s == 0 && !cond_met(x[1:0]))
            begin
                finish_instr(5'd8);
                return;
            end
            if (pop_word(s, d))
            begin
                pc = tmp;
                finish_instr(5'd20);
            end
            return;
        end
        if ((op & 8'hCF) == 8'h02 || (op & 8'hCF) == 8'h0A)
        begin
            load = op[3];
            if (s == 0)
            begin
                a = (p < PAIR_HL) ? reg_pair(p) : hl_word();
                if (load) bus_read(a);
                else bus_store(a, acc);
                if (p == PAIR_HL) set_reg_pair(PAIR_HL, a + 16'd1);
                if (p == PAIR_SP) set_reg_pair(PAIR_HL, a - 16'd1);
            end
            else
            begin
                if (load) acc = d;
                finish_instr(5'd8);
            end
            return;
        end
        if ((op & 8'hEF) == 8'hEA)
        begin
            if (s <= 2)
            begin
                if (imm16(s, d))
                begin
                    if (hi_ld) bus_read(tmp);
                    else bus_store(tmp, acc);
                end
            end
            else
            begin
                if (hi_ld) acc = d;
                finish_instr(5'd16);
            end
            return;
        end
        if ((op & 8'hEF) == 8'hE0)
        begin
            if (s == 0) fetch_pc();
            else if (s == 1)
            begin
                a = HIGH_PAGE | {8'h00, d};
                if (hi_ld) bus_read(a);
                else bus_store(a, acc);
            end
            else
            begin
                if (hi_ld) acc = d;
                finish_instr(5'd12);
            end
            return;
        end
        if ((op & 8'hEF) == 8'hE2)
        begin
            if (s == 0)
            begin
                a = HIGH_PAGE | {8'h00, gpr[REG_C]};
                if (hi_ld) bus_read(a);
                else bus_store(a, acc);
            end
            else
            begin
                if (hi_ld) acc = d;
                finish_instr(5'd8);
            end
            return;
        end
        if ((op & 8'hC7) == 8'h03)
        begin
            set_reg_pair(p, op[3] ? reg_pair(p) - 16'd1 : reg_pair(p) + 16'd1);
            finish_instr(5'd8);
            return;
        end
        if ((op & 8'hCF) == 8'h09)
        begin
            wa = hl_word();
            wb = reg_pair(p);
            set_reg_pair(PAIR_HL, 16'(wa + wb));
            set_flags(flags[3], 1'b0, (wa % 4096) + (wb % 4096) > 4095, wa + wb > 65535);
            finish_instr(5'd8);
            return;
        end
        if ((op & 8'hC7) == 8'hC6)
        begin
            if (s == 0) fetch_pc();
            else
            begin
                alu_exec(x, d);
                finish_instr(5'd8);
            end
            return;
        end
        case (op)
            OP_NOP: finish_instr(5'd4);
            OP_LDSP:
            begin
                if (s <= 2)
                begin
                    if (imm16(s, d)) bus_store(tmp, sp[7:0]);
                end
                else if (s == 3) bus_store(tmp + 16'd1, sp[15:8]);
                else finish_instr(5'd20);
            end
            OP_JR:
            begin
                if (s == 0) fetch_pc();
                else
                begin
                    pc = pc + sext16(d);
                    finish_instr(5'd12);
                end
            end
            OP_JP:
            begin
                if (imm16(s, d))
                begin
                    pc = tmp;
                    finish_instr(5'd16);
                end
            end
            OP_CALL: call_step(s, d, 1'b1);
            OP_RET:
            begin
                if (pop_word(s, d))
                begin
                    pc = tmp;
                    finish_instr(5'd16);
                end
            end
            OP_ADDSP:
            begin
                if (s == 0) fetch_pc();
                else sp_offset(d, 1'b0, 5'd16);
            end
            OP_JPHL:
            begin
                pc = hl_word();
                finish_instr(5'd4);
            end
            OP_LDHLSP:
            begin
                if (s == 0) fetch_pc();
                else sp_offset(d, 1'b1, 5'd12);
            end
            OP_LDSPHL:
            begin
                sp = hl_word();
                finish_instr(5'd8);
            end
            default:
            begin
                finish_instr(5'd0);
                rq_unh = 1'b1;
            end
        endcase
    endfunction

    function automatic req_t next_bus_request(input logic [7:0] d);
        req_t r;
        bit   done;
        done = 1'b0;
        rq_cyc = 5'd0;
        rq_unh = 1'b0;
        rq_more = 1'b0;
        if (mstep == 0)
        begin
            pc = start_reg;
            sp = stack_reg;
        end
        else
        begin
            if (mstep == 1)
                op_latch = d;
            exec_op(op_latch, mstep - 3'd1, d);
            done = !rq_more;
        end
        if (rq_more)
            mstep = mstep + 3'd1;
        else
        begin
            fetch_pc();
            mstep = 3'd1;
        end
        r.bus_address      = rq_addr;
        r.bus_write        = rq_wr;
        r.bus_write_data   = rq_wr ? rq_data : 8'h00;
        r.instr_done       = done;
        r.instr_cycles     = done ? rq_cyc : 5'd0;
        r.unhandled_opcode = done && rq_unh;
        return r;
    endfunction

    task automatic report(input string what, input logic [15:0] want, input logic [15:0] got);
        $display("%0t bus request %s: expected %h, got %h", $time, what, want, got);
        errors++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        req_t want;
        if (!rst_n)
        begin
            start_reg = START_RESET;
            stack_reg = STACK_RESET;
            acc = 8'h00;
            flags = 4'h0;
            foreach (gpr[i])
                gpr[i] = 8'h00;
            sp = STACK_RESET;
            pc = START_RESET;
            op_latch = 8'h00;
            mstep = 3'd0;
            tmp = 16'h0000;
            rq_addr = 16'h0000;
            rq_wr = 1'b0;
            rq_data = 8'h00;
            rq_more = 1'b0;
            rq_cyc = 5'd0;
            rq_unh = 1'b0;
            expected_reqs.delete();
            errors = 0;
            backlog = 0;
        end
        else
        begin
            if (out_ch.valid && out_ch.ready)
            begin
                if (expected_reqs.size() == 0)
                    report("with none pending, address", 16'h0000, out_ch.bus_address);
                else
                begin
                    want = expected_reqs.pop_front();
                    if (out_ch.bus_address !== want.bus_address)
                        report("bus_address", want.bus_address, out_ch.bus_address);
                    if (out_ch.bus_write !== want.bus_write)
                        report("bus_write", want.bus_write, out_ch.bus_write);
                    if (out_ch.bus_write_data !== want.bus_write_data)
                        report("bus_write_data", want.bus_write_data, out_ch.bus_write_data);
                    if (out_ch.instr_done !== want.instr_done)
                        report("instr_done", want.instr_done, out_ch.instr_done);
                    if (out_ch.instr_cycles !== want.instr_cycles)
                        report("instr_cycles", want.instr_cycles, out_ch.instr_cycles);
                    if (out_ch.unhandled_opcode !== want.unhandled_opcode)
                        report("unhandled_opcode", want.unhandled_opcode, out_ch.unhandled_opcode);
                end
            end
            if (in_ch.valid && in_ch.ready)
                expected_reqs.push_back(next_bus_request(in_ch.read_data));
            if (cfg.valid && cfg.ready)
            begin
                if (cfg.index == CFG_START_ADDRESS)
                    start_reg = cfg.data;
                else
                    stack_reg = cfg.data;
            end
            backlog = expected_reqs.size();
        end
    end
endmodule

FILE: tb/sv/tb_sm83_cpu_core_subset.sv
`timescale 1ns / 1ps
// testbench top for the sm83 core subset: clock, reset, stimulus, stalls and verdict
module tb_sm83_cpu_core_subset;
    import sm83_pkg::*;

    localparam int STALL_LIMIT = 2000;
    localparam int LONG_HOLD   = 300;
    localparam int PHASE_ITEMS = 300;

    logic clk;
    logic rst_n;
    int   errors, backlog;
    int   sent_cnt = 0;
    int   got_cnt = 0;
    int   quiet_cycles = 0;
    bit   no_idle = 1'b0;
    bit   hold_go = 1'b0;
    bit   hold_done = 1'b0;
    int   hold_left = 0;

    sm83_in_if  in_ch();
    sm83_out_if out_ch();
    sm83_cfg_if cfg();

    sm83_cpu_core_subset dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch),
        .cfg    (cfg)
    );

    sm83_bus_checker checker_i (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_ch   (in_ch),
        .out_ch  (out_ch),
        .cfg     (cfg),
        .errors  (errors),
        .backlog (backlog)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // transfer counts and watchdog
    always @(posedge clk)
    begin
        if (in_ch.valid && in_ch.ready)
            sent_cnt <= sent_cnt + 1;
        if (out_ch.valid && out_ch.ready)
            got_cnt <= got_cnt + 1;
        if (rst_n)
        begin
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)
                || (cfg.valid && cfg.ready))
                quiet_cycles <= 0;
            else if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("sm83_cpu_core_subset: mismatch");
                $finish;
            end
            else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

    // receiver side
    initial
    begin
        out_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_go && !hold_done)
            begin
                hold_done = 1'b1;
                hold_left = LONG_HOLD;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ch.ready <= 1'b0;
            end
            else if (no_idle)
                out_ch.ready <= 1'b1;
            else
                out_ch.ready <= ($urandom_range(99) >= 6);
        end
    end

    task automatic send_byte(input logic [7:0] d);
        int gap;
        if (!no_idle && $urandom_range(99) < 6)
        begin
            gap = $urandom_range(4, 1);
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.read_data <= d;
        do
            @(posedge clk);
        while (!in_ch.ready);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] value);
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.data <= value;
        do
            @(posedge clk);
        while (!cfg.ready);
        cfg.valid <= 1'b0;
    endtask

    task automatic drain();
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (sent_cnt != got_cnt)
            @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    function automatic logic [7:0] pick_byte();
        logic [7:0] edge_vals [8] = '{8'h00, 8'hFF, 8'h80, 8'h7F, 8'h01, 8'h0F, 8'hF0, 8'h10};
        if ($urandom_range(99) < 20)
            return edge_vals[$urandom_range(7)];
        return 8'($urandom_range(255));
    endfunction

    // first byte is ignored; then ld a,d8 / add / sbc / cb prefix / halt / push af / pop af /
    // add sp,e / ld hl,sp+e / call / ret
    logic [7:0] directed_bytes [25] = '{
        8'h00, 8'h3E, 8'hFF, 8'hC6, 8'h01, 8'hDE, 8'h80, 8'hCB, OP_HALT, 8'hF5,
        8'h00, 8'h00, 8'hF1, 8'h34, 8'h12, OP_ADDSP, 8'h80, OP_LDHLSP, 8'h7F, OP_CALL,
        8'hFF, 8'hFF, 8'h00, 8'h00, OP_RET
    };

    initial
    begin
        rst_n <= 1'b0;
        in_ch.valid <= 1'b0;
        in_ch.read_data <= 8'h00;
        cfg.valid <= 1'b0;
        cfg.index <= CFG_START_ADDRESS;
        cfg.data <= 16'h0000;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        write_reg(CFG_START_ADDRESS, 16'hFFFE);
        write_reg(CFG_STACK_START, 16'h0000);

        foreach (directed_bytes[i])
        begin
            send_byte(directed_bytes[i]);
            drain();
        end

        for (int phase = 0; phase < 4; phase++)
        begin
            for (int i = 0; i < PHASE_ITEMS; i++)
            begin
                if (phase == 1)
                    no_idle = (i < 200);
                if (phase == 2 && i == 50)
                    hold_go = 1'b1;
                send_byte(pick_byte());
            end
            drain();
            // writes after the first transfer are not used, since reset restores the defaults
            case (phase)
                0:
                begin
                    write_reg(CFG_START_ADDRESS, 16'h0000);
                    write_reg(CFG_STACK_START, 16'h0000);
                end
                1:
                begin
                    write_reg(CFG_START_ADDRESS, 16'hFFFF);
                    write_reg(CFG_STACK_START, 16'hFFFF);
                end
                default:
                begin
                    write_reg(CFG_START_ADDRESS, 16'($urandom_range(65535)));
                    write_reg(CFG_STACK_START, 16'($urandom_range(65535)));
                end
            endcase
        end

        drain();
        repeat (10) @(posedge clk);
        if (errors == 0 && backlog == 0)
            $display("sm83_cpu_core_subset: match");
        else
            $display("sm83_cpu_core_subset: mismatch");
        $finish;
    end
endmodule

FILE: filelist.f
design/sm83_pkg.sv
design/sm83_if.sv
design/sm83_exec.sv
design/sm83_cpu_core_subset.sv
design/sm83_checker.sv
tb/sv/sm83_bus_checker.sv
tb/sv/tb_sm83_cpu_core_subset.sv
